// ----- src/trapezoid_current_profile_generator_macros.svh -----
// assertion macros shared by the rtl
`ifndef TRAPEZOID_CURRENT_PROFILE_GENERATOR_MACROS_SVH
`define TRAPEZOID_CURRENT_PROFILE_GENERATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent holds in a cycle, consequent holds in the same cycle
`define TCPG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcpg assertion failed");

// antecedent holds in a cycle, consequent holds in the next one
`define TCPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcpg assertion failed");

`else

`define TCPG_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TCPG_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/tcpg_pkg.sv -----
package tcpg_pkg;

  localparam int unsigned CurrentWidthDef = 16;

  localparam int unsigned PeakW   = 15;
  localparam int unsigned LenW    = 16;
  localparam int unsigned SegW    = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned InDataW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // divider: peak * k / n, quotient never exceeds the peak
  localparam int unsigned DvdW = PeakW + LenW;
  localparam int unsigned DivW = LenW;
  localparam int unsigned QuoW = PeakW;
  localparam int unsigned DivCntW = $clog2(QuoW + 1);

  localparam logic [PeakW-1:0] PeakRst = '0;
  localparam logic [LenW-1:0]  RampRst = 16'd500;
  localparam logic [LenW-1:0]  HoldRst = 16'd500;
  localparam logic [LenW-1:0]  ZeroRst = 16'd100;

  typedef enum logic [CmdW-1:0] {
    CmdTick  = 2'd0,
    CmdStart = 2'd1,
    CmdStop  = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StatOk      = 2'd0,
    StatStopped = 2'd1,
    StatFault   = 2'd2,
    StatIgnored = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegPeak = 2'd0,
    RegRamp = 2'd1,
    RegHold = 2'd2,
    RegZero = 2'd3
  } reg_idx_e;

endpackage

// ----- src/trapezoid_current_profile_generator.sv -----
// channel   dir  tdata / data                               tuser
// s_axis    in   [1:0] cmd                                   [0] drive_fault
// m_axis    out  setpoint, drive_enable, segment_index, status  -
// cfg       in   cfg_index_i register, cfg_data_i value      -
//
// start, stop and ticks outside a ramp answer from the accept cycle: the result is registered, valid in the next cycle.
// a ramp tick passes through multiply, divider load, 15 divider steps and the result register.
// the divider (one restoring step per cycle) sets the ramp tick latency.
// rst_ni clears the run state and loads the register defaults; no clearing pass.
// input ready drops while a ramp tick is in flight or the result beat is stalled.
module trapezoid_current_profile_generator #(
  parameter int unsigned CURRENT_WIDTH = tcpg_pkg::CurrentWidthDef,
  localparam int unsigned OutW = ((CURRENT_WIDTH + 6 + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [tcpg_pkg::InDataW-1:0]     s_axis_tdata_i,   // cmd
  input  logic                             s_axis_tuser_i,   // drive_fault
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [OutW-1:0]                  m_axis_tdata_o,   // setpoint, drive_enable,
                                                             // segment_index, status
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tcpg_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [tcpg_pkg::CfgDataW-1:0]    cfg_data_i
);
  import tcpg_pkg::*;

  `include "trapezoid_current_profile_generator_macros.svh"

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StDivGo,
    StDiv
  } state_e;

  localparam logic signed [32:0] SatHi = 33'((64'sd1 <<< (CURRENT_WIDTH - 1)) - 64'sd1);
  localparam logic signed [32:0] SatLo = -SatHi;

  function automatic logic [CURRENT_WIDTH-1:0] sat(input logic signed [PeakW+1:0] v);
    logic signed [32:0] w;
    w = 33'(v);
    if (w > SatHi) w = SatHi;
    if (w < SatLo) w = SatLo;
    return w[CURRENT_WIDTH-1:0];
  endfunction

  state_e state_q, state_d;

  logic [PeakW-1:0] peak_cfg_q, peak_cfg_d;
  logic [LenW-1:0]  ramp_q, ramp_d;
  logic [LenW-1:0]  hold_q, hold_d;
  logic [LenW-1:0]  zero_q, zero_d;

  logic             active_q, active_d;
  logic             run_req_q, run_req_d;
  logic [SegW-1:0]  seg_q, seg_d;
  logic [LenW-1:0]  tick_q, tick_d;
  logic [PeakW-1:0] peak_q, peak_d;

  logic [1:0]       rdir_q, rdir_d;
  logic [LenW-1:0]  k_q, k_d;
  logic [LenW-1:0]  n_q, n_d;
  logic [DvdW-1:0]  prod_q, prod_d;

  logic                     out_valid_q, out_valid_d;
  logic [CURRENT_WIDTH-1:0] out_sp_q, out_sp_d;
  logic                     out_en_q, out_en_d;
  logic [SegW-1:0]          out_seg_q, out_seg_d;
  status_e                  out_stat_q, out_stat_d;

  logic              accept;
  cmd_e              cmd;
  logic [LenW-1:0]   cur_len;
  logic [LenW:0]     k_raw;
  logic              div_start;
  logic              div_done;
  logic [QuoW-1:0]   quot;
  logic signed [PeakW+1:0] r_s, p_s, ramp_val;

  assign s_axis_tready_o = (state_q == StIdle) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd             = cmd_e'(s_axis_tdata_i[CmdW-1:0]);
  assign cfg_ready_o     = 1'b1;

  // a zero length acts as one
  always_comb begin
    if (!seg_q[0]) begin
      cur_len = (ramp_q == '0) ? LenW'(1) : ramp_q;
    end else if (!seg_q[1]) begin
      cur_len = (hold_q == '0) ? LenW'(1) : hold_q;
    end else begin
      cur_len = (zero_q == '0) ? LenW'(1) : zero_q;
    end
  end

  assign k_raw = {1'b0, tick_q} + 1'b1;

  assign div_start = (state_q == StDivGo);

  tcpg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign r_s = {2'b00, quot};
  assign p_s = {2'b00, peak_q};

  always_comb begin
    case (rdir_q)
      2'd0:    ramp_val = r_s;
      2'd1:    ramp_val = p_s - r_s;
      2'd2:    ramp_val = -r_s;
      default: ramp_val = r_s - p_s;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    peak_cfg_d  = peak_cfg_q;
    ramp_d      = ramp_q;
    hold_d      = hold_q;
    zero_d      = zero_q;
    active_d    = active_q;
    run_req_d   = run_req_q;
    seg_d       = seg_q;
    tick_d      = tick_q;
    peak_d      = peak_q;
    rdir_d      = rdir_q;
    k_d         = k_q;
    n_d         = n_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_sp_d    = out_sp_q;
    out_en_d    = out_en_q;
    out_seg_d   = out_seg_q;
    out_stat_d  = out_stat_q;

    if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        RegPeak: peak_cfg_d = cfg_data_i[PeakW-1:0];
        RegRamp: ramp_d     = cfg_data_i[LenW-1:0];
        RegHold: hold_d     = cfg_data_i[LenW-1:0];
        RegZero: zero_d     = cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          out_valid_d = 1'b1;
          out_sp_d    = '0;
          out_stat_d  = StatOk;
          out_seg_d   = seg_q;
          out_en_d    = active_q;
          unique case (cmd)
            CmdTick: begin
              if (!active_q) begin
                out_seg_d = '0;
              end else if (!run_req_q) begin
                out_stat_d = StatStopped;
                out_en_d   = 1'b0;
                active_d   = 1'b0;
                run_req_d  = 1'b0;
              end else if (s_axis_tuser_i) begin
                out_stat_d = StatFault;
                out_en_d   = 1'b0;
                active_d   = 1'b0;
                run_req_d  = 1'b0;
              end else begin
                if (k_raw >= {1'b0, cur_len}) begin
                  tick_d = '0;
                  seg_d  = seg_q + 1'b1;
                end else begin
                  tick_d = k_raw[LenW-1:0];
                end
                if (!seg_q[0]) begin
                  // ramp point: hold the beat until the divide is done
                  out_valid_d = 1'b0;
                  state_d     = StMul;
                  rdir_d      = seg_q[2:1];
                  n_d         = cur_len;
                  k_d         = (k_raw > {1'b0, cur_len}) ? cur_len : k_raw[LenW-1:0];
                end else if (seg_q[1]) begin
                  out_sp_d = '0;
                end else if (seg_q[2]) begin
                  out_sp_d = sat(-p_s);
                end else begin
                  out_sp_d = sat(p_s);
                end
              end
            end
            CmdStart: begin
              if (active_q) begin
                out_stat_d = StatIgnored;
              end else begin
                peak_d    = peak_cfg_q;
                active_d  = 1'b1;
                run_req_d = 1'b1;
                seg_d     = '0;
                tick_d    = '0;
                out_seg_d = '0;
                out_en_d  = 1'b1;
              end
            end
            CmdStop: begin
              if (active_q) run_req_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      StMul: begin
        prod_d  = DvdW'(peak_q * k_q);
        state_d = StDivGo;
      end
      StDivGo: begin
        state_d = StDiv;
      end
      StDiv: begin
        if (div_done) begin
          out_sp_d    = sat(ramp_val);
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      peak_cfg_q  <= PeakRst;
      ramp_q      <= RampRst;
      hold_q      <= HoldRst;
      zero_q      <= ZeroRst;
      active_q    <= 1'b0;
      run_req_q   <= 1'b0;
      seg_q       <= '0;
      tick_q      <= '0;
      peak_q      <= '0;
      rdir_q      <= '0;
      k_q         <= '0;
      n_q         <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_sp_q    <= '0;
      out_en_q    <= 1'b0;
      out_seg_q   <= '0;
      out_stat_q  <= StatOk;
    end else begin
      state_q     <= state_d;
      peak_cfg_q  <= peak_cfg_d;
      ramp_q      <= ramp_d;
      hold_q      <= hold_d;
      zero_q      <= zero_d;
      active_q    <= active_d;
      run_req_q   <= run_req_d;
      seg_q       <= seg_d;
      tick_q      <= tick_d;
      peak_q      <= peak_d;
      rdir_q      <= rdir_d;
      k_q         <= k_d;
      n_q         <= n_d;
      prod_q      <= prod_d;
      out_valid_q <= out_valid_d;
      out_sp_q    <= out_sp_d;
      out_en_q    <= out_en_d;
      out_seg_q   <= out_seg_d;
      out_stat_q  <= out_stat_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutW'({out_stat_q, out_seg_q, out_en_q, out_sp_q});

  `TCPG_ASSERT_SAME(a_busy_not_ready, clk_i, rst_ni, state_q != StIdle, !s_axis_tready_o)
  `TCPG_ASSERT_SAME(a_idle_no_run, clk_i, rst_ni, !active_q, !run_req_q)
  `TCPG_ASSERT_SAME(a_disabled_zero, clk_i, rst_ni, out_valid_q && !out_en_q,
                    out_sp_q == '0)
  `TCPG_ASSERT_NEXT(a_div_result_out, clk_i, rst_ni, state_q == StDiv && div_done,
                    out_valid_q && out_en_q)

endmodule

// ----- src/tcpg_div.sv -----
module tcpg_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tcpg_pkg::DvdW-1:0]     dividend_i,
  input  logic [tcpg_pkg::DivW-1:0]     divisor_i,
  output logic                          done_o,
  output logic [tcpg_pkg::QuoW-1:0]     quot_o
);
  import tcpg_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]    rem_q, rem_d;
  logic [QuoW-1:0]    quo_q, quo_d;
  logic [DivW-1:0]    div_q, div_d;
  logic [DivW:0]      shifted;
  logic [DivW:0]      diff;
  logic               ge;

  // one restoring step per cycle; the high dividend half is already below the divisor
  assign shifted = {rem_q, quo_q[QuoW-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign ge      = shifted >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(QuoW);
      rem_d  = dividend_i[DvdW-1:QuoW];
      quo_d  = dividend_i[QuoW-1:0];
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DivW-1:0] : shifted[DivW-1:0];
      quo_d = {quo_q[QuoW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import tcpg_pkg::*;

  localparam int unsigned OutW = ((CurrentWidthDef + 6 + 7) / 8) * 8;
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                s_axis_tuser_i = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutW-1:0]     m_axis_tdata_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  typedef struct packed {
    logic [CurrentWidthDef-1:0] setpoint;
    logic                       enable;
    logic [SegW-1:0]            seg;
    status_e                    status;
  } profile_beat_t;

  class profile_scoreboard;
    logic [PeakW-1:0] peak_reg;
    logic [LenW-1:0]  ramp_reg, hold_reg, zero_reg;
    logic             running, run_req;
    logic [SegW-1:0]  seg;
    logic [LenW-1:0]  seg_pos;
    logic [PeakW-1:0] peak_held;
    profile_beat_t    due_beats[$];
    int               errors, cmds_seen, beats_seen;
    int               status_seen[4];

    function new();
      peak_reg = PeakRst;
      ramp_reg = RampRst;
      hold_reg = HoldRst;
      zero_reg = ZeroRst;
      running = 1'b0;
      run_req = 1'b0;
      seg = '0;
      seg_pos = '0;
      peak_held = '0;
      errors = 0;
      cmds_seen = 0;
      beats_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_register(reg_idx_e idx, logic [CfgDataW-1:0] v);
      case (idx)
        RegPeak: peak_reg = v[PeakW-1:0];
        RegRamp: ramp_reg = v;
        RegHold: hold_reg = v;
        RegZero: zero_reg = v;
        default: ;
      endcase
    endfunction

    // a programmed length of zero behaves as one tick
    function logic [LenW-1:0] seg_len(logic [SegW-1:0] s);
      logic [LenW-1:0] n;
      if (!s[0]) n = ramp_reg;
      else if (s == 3'd1 || s == 3'd5) n = hold_reg;
      else n = zero_reg;
      return (n == '0) ? 16'd1 : n;
    endfunction

    function longint seg_level(logic [SegW-1:0] s, logic [LenW-1:0] pos);
      longint p, r, k, n;
      p = longint'(peak_held);
      r = 0;
      if (!s[0]) begin
        n = longint'(seg_len(s));
        k = longint'(pos) + 1;
        if (k > n) k = n;
        r = (p * k) / n;
      end
      case (s)
        3'd0: return r;
        3'd1: return p;
        3'd2: return p - r;
        3'd4: return -r;
        3'd5: return -p;
        3'd6: return -p + r;
        default: return 0;
      endcase
    endfunction

    function void note_command(logic [CmdW-1:0] c, logic f);
      profile_beat_t   b;
      logic [LenW-1:0] n;
      b.setpoint = '0;
      b.seg = seg;
      b.status = StatOk;
      case (c)
        CmdTick: begin
          if (!running) begin
            b.seg = '0;
          end else if (!run_req) begin
            b.status = StatStopped;
            running = 1'b0;
          end else if (f) begin
            b.status = StatFault;
            running = 1'b0;
            run_req = 1'b0;
          end else begin
            n = seg_len(seg);
            b.setpoint = CurrentWidthDef'(seg_level(seg, seg_pos));
            seg_pos = seg_pos + 16'd1;
            if (seg_pos >= n) begin
              seg_pos = '0;
              seg = seg + 3'd1;
            end
          end
        end
        CmdStart: begin
          if (running) begin
            b.status = StatIgnored;
          end else begin
            peak_held = peak_reg;
            running = 1'b1;
            run_req = 1'b1;
            seg = '0;
            seg_pos = '0;
            b.seg = '0;
          end
        end
        CmdStop: begin
          if (running) run_req = 1'b0;
        end
        default: ;
      endcase
      b.enable = running;
      cmds_seen++;
      status_seen[b.status]++;
      due_beats.push_back(b);
    endfunction

    function void check_beat(logic [OutW-1:0] d);
      profile_beat_t e;
      if (due_beats.size() == 0) begin
        $error("result beat %h with nothing expected", d);
        errors++;
        return;
      end
      e = due_beats.pop_front();
      beats_seen++;
      if (d[15:0] !== e.setpoint) begin
        $error("setpoint: expected %0d, actual %0d", $signed(e.setpoint), $signed(d[15:0]));
        errors++;
      end
      if (d[16] !== e.enable) begin
        $error("drive_enable: expected %0d, actual %0d", e.enable, d[16]);
        errors++;
      end
      if (d[19:17] !== e.seg) begin
        $error("segment_index: expected %0d, actual %0d", e.seg, d[19:17]);
        errors++;
      end
      if (d[21:20] !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, d[21:20]);
        errors++;
      end
    endfunction
  endclass

  profile_scoreboard profile_sb = new();

  trapezoid_current_profile_generator u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) profile_sb.check_beat(m_axis_tdata_o);
  end

  task automatic set_idle_mode(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 24;
        recv_idle_pct = 53;
      end
      1: begin
        send_idle_pct = 53;
        recv_idle_pct = 24;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // valid stays high across back-to-back beats; it only drops in a gap
  task automatic send_command(input logic [CmdW-1:0] c, input logic f);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= InDataW'(c);
    s_axis_tuser_i <= f;
    do @(posedge clk_i); while (!s_axis_tready_o);
    profile_sb.note_command(c, f);
  endtask

  task automatic finish_outstanding();
    s_axis_tvalid_i <= 1'b0;
    while (profile_sb.due_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    profile_sb.set_register(idx, v);
  endtask

  task automatic program_profile(input logic [CfgDataW-1:0] peak, ramp, hold, zero);
    finish_outstanding();
    write_reg(RegPeak, peak);
    write_reg(RegRamp, ramp);
    write_reg(RegHold, hold);
    write_reg(RegZero, zero);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly short segments so whole cycles get through, now and then huge ones
  function automatic logic [CfgDataW-1:0] pick_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 15) return 16'hffff;
    if (roll < 25) return CfgDataW'($urandom_range(0, 65535));
    return CfgDataW'($urandom_range(1, 6));
  endfunction

  function automatic logic [CfgDataW-1:0] pick_peak();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return 16'h7fff;
    if (roll < 30) return 16'hffff;
    if (roll < 40) return '0;
    return CfgDataW'($urandom_range(0, 65535));
  endfunction

  task automatic run_sessions(input int budget);
    int sent, ticks, roll;
    sent = 0;
    while (sent < budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        send_command(CmdW'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        send_command(CmdStart, 1'($urandom_range(0, 1)));
        sent++;
        ticks = $urandom_range(4, 40);
        repeat (ticks) begin
          roll = $urandom_range(0, 99);
          if (roll < 3) send_command(CmdStart, 1'b0);
          else if (roll < 5) send_command(CmdUnused, 1'($urandom_range(0, 1)));
          else send_command(CmdTick, $urandom_range(0, 99) < 2);
          sent++;
        end
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          send_command(CmdStop, 1'($urandom_range(0, 1)));
          send_command(CmdTick, 1'($urandom_range(0, 1)));
          sent += 2;
        end else if (roll < 75) begin
          send_command(CmdTick, 1'b1);
          sent++;
        end
        // otherwise the profile keeps running into the next setting
      end
    end
  endtask

  initial begin
    set_idle_mode(0);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle tick with reset register values, fault flag has no effect
    send_command(CmdTick, 1'b1);
    program_profile(16'h7fff, 16'd2, 16'd1, 16'd1);
    send_command(CmdStop, 1'b0);
    send_command(CmdUnused, 1'b0);
    send_command(CmdStart, 1'b0);
    send_command(CmdStart, 1'b0);
    repeat (12) send_command(CmdTick, 1'b0);
    send_command(CmdStop, 1'b0);
    // start is ignored while the stop is pending, stop wins over the fault
    send_command(CmdStart, 1'b0);
    send_command(CmdTick, 1'b1);
    send_command(CmdStart, 1'b1);
    send_command(CmdTick, 1'b1);

    // segment lengths cut down while the ramp is in progress
    program_profile(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_command(CmdStart, 1'b0);
    repeat (3) send_command(CmdTick, 1'b0);
    program_profile(16'd1, 16'd0, 16'd0, 16'd0);
    repeat (5) send_command(CmdTick, 1'b0);
    send_command(CmdUnused, 1'b1);
    send_command(CmdStop, 1'b1);
    send_command(CmdTick, 1'b0);

    for (int p = 0; p < 11; p++) begin
      program_profile(pick_peak(), pick_len(), pick_len(), pick_len());
      set_idle_mode((p * 3) / 11);
      run_sessions(35);
    end

    finish_outstanding();
    repeat (20) @(posedge clk_i);
    $display("commands accepted: %0d, result beats checked: %0d",
             profile_sb.cmds_seen, profile_sb.beats_seen);
    $display("status mix: ok %0d, stopped %0d, faulted %0d, start ignored %0d",
             profile_sb.status_seen[StatOk], profile_sb.status_seen[StatStopped],
             profile_sb.status_seen[StatFault], profile_sb.status_seen[StatIgnored]);
    if (profile_sb.errors == 0 && profile_sb.due_beats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
